>>> rtl/tpes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpes_pkg;

  localparam int TILE_PIXELS = 64;
  localparam int IDX_W       = $clog2(TILE_PIXELS);
  localparam int CNT_W       = $clog2(TILE_PIXELS + 1);
  localparam int COLOR_W     = 24;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic               opaque;
    logic [COLOR_W-1:0] color;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   orig;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

endpackage
`default_nettype wire

>>> rtl/tile_palette_extract_sort_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake          beat
// pixel     in         push / full        pixel_color
// result    out        empty / pop        pixel_opaque .. last_of_tile
// key cfg   in         cfg_we             cfg_data
//
// Pixels enter at up to one per cycle, while the back is loading, through a
// four-deep queue and are matched combinationally against all palette cells.
// After the 64th pixel the tile copies the palette, runs a quicksort,
// inverts the order and emits the results.
// Reset is synchronous; the back takes no pixels from the copy through emission, so
// the queue fills after four and holds full; results wait for pop.
module tile_palette_extract_sort_unit
  import tpes_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  wire  [COLOR_W-1:0] pixel_color,
  output logic               empty,
  input  wire                pop,
  output logic               pixel_opaque,
  output logic [IDX_W-1:0]   pixel_palette_index,
  output logic [COLOR_W-1:0] entry_color,
  output logic [CNT_W-1:0]   entry_count,
  output logic [CNT_W-1:0]   color_total,
  output logic [CNT_W-1:0]   opaque_total,
  output logic               last_of_tile,
  input  wire                cfg_we,
  input  wire  [COLOR_W-1:0] cfg_data
);

  logic [COLOR_W-1:0] key;
  logic               item_pop;
  logic               item_valid;
  item_t              item;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      key <= cfg_data;
    end
  end

  tpes_front u_front (
    .clk(clk), .rst(rst), .push(push), .pixel_color(pixel_color), .key(key),
    .full(full), .item_pop(item_pop), .item_valid(item_valid), .item(item)
  );

  tpes_back u_back (
    .clk(clk), .rst(rst), .key(key), .item_valid(item_valid), .item(item),
    .item_pop(item_pop), .empty(empty), .pop(pop), .pixel_opaque(pixel_opaque),
    .pixel_palette_index(pixel_palette_index), .entry_color(entry_color),
    .entry_count(entry_count), .color_total(color_total), .opaque_total(opaque_total),
    .last_of_tile(last_of_tile)
  );

endmodule
`default_nettype wire

>>> rtl/tpes_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tpes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

>>> rtl/tpes_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tpes_front
  import tpes_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire  [COLOR_W-1:0] pixel_color,
  input  wire  [COLOR_W-1:0] key,
  output logic               full,
  input  wire                item_pop,
  output logic               item_valid,
  output item_t              item
);

  item_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp;
  logic [FIFO_AW-1:0]   rp;
  logic [FIFO_AW:0]     fill;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (fill == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign item_valid = (fill != '0);
  assign item       = mem[rp];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  // judge transparency by the key at arrival
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= '{opaque: (pixel_color != key), color: pixel_color};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      fill <= fill + (FIFO_AW + 1)'(do_push) - (FIFO_AW + 1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/tpes_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tpes_back
  import tpes_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire  [COLOR_W-1:0] key,
  input  wire                item_valid,
  input  item_t              item,
  output logic               item_pop,
  output logic               empty,
  input  wire                pop,
  output logic               pixel_opaque,
  output logic [IDX_W-1:0]   pixel_palette_index,
  output logic [COLOR_W-1:0] entry_color,
  output logic [CNT_W-1:0]   entry_count,
  output logic [CNT_W-1:0]   color_total,
  output logic [CNT_W-1:0]   opaque_total,
  output logic               last_of_tile
);

  localparam logic [4:0] ST_LOAD     = 5'd0;
  localparam logic [4:0] ST_COPY     = 5'd1;
  localparam logic [4:0] ST_INIT     = 5'd2;
  localparam logic [4:0] ST_POP      = 5'd3;
  localparam logic [4:0] ST_POPW     = 5'd4;
  localparam logic [4:0] ST_PIV      = 5'd5;
  localparam logic [4:0] ST_PIVW     = 5'd6;
  localparam logic [4:0] ST_SCAN_RD  = 5'd7;
  localparam logic [4:0] ST_SCAN_CHK = 5'd8;
  localparam logic [4:0] ST_SWAP2    = 5'd9;
  localparam logic [4:0] ST_FIN_RD   = 5'd10;
  localparam logic [4:0] ST_FIN_W1   = 5'd11;
  localparam logic [4:0] ST_FIN_W2   = 5'd12;
  localparam logic [4:0] ST_PUSH1    = 5'd13;
  localparam logic [4:0] ST_PUSH2    = 5'd14;
  localparam logic [4:0] ST_INV      = 5'd15;
  localparam logic [4:0] ST_EM_RD    = 5'd16;
  localparam logic [4:0] ST_EM_MAP   = 5'd17;
  localparam logic [4:0] ST_EM_OUT   = 5'd18;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TILE_PIXELS - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TILE_PIXELS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TILE_PIXELS);

  logic [4:0]         state;
  logic [COLOR_W-1:0] col [TILE_PIXELS];
  logic [CNT_W-1:0]   cnt [TILE_PIXELS];
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   opq;
  logic [IDX_W-1:0]   pos;
  logic [CNT_W-1:0]   kc;
  logic [CNT_W-1:0]   top;
  logic [IDX_W-1:0]   lo;
  logic [IDX_W-1:0]   hi;
  logic [IDX_W-1:0]   ip;
  logic [IDX_W-1:0]   j;
  logic [CNT_W-1:0]   pivot;
  entry_t             tmp;
  logic               em_op;
  entry_t             em_ent;
  logic               out_valid;

  logic [TILE_PIXELS-1:0] lane_hit;
  logic                   hit;
  logic [IDX_W-1:0]       g_hit;
  logic [IDX_W-1:0]       g_sel;
  logic                   load_go;
  logic                   out_free;
  logic                   tile_done;
  logic                   j_last;

  logic             s_we;
  logic [IDX_W-1:0] s_wa, s_ra, s_rb;
  entry_t           s_wd, s_da, s_db;
  logic             m_we;
  logic [IDX_W:0]   m_wd, m_rd;
  logic             p_we;
  logic [IDX_W-1:0] p_wa, p_wd, p_rd;
  logic             k_we;
  range_t           k_wd, k_rd;
  logic [CNT_W-1:0] top_dec;

  // parallel colour match over the palette cells
  always_comb begin
    hit   = 1'b0;
    g_hit = '0;
    for (int i = 0; i < TILE_PIXELS; i++) begin
      lane_hit[i] = (CNT_W'(i) < fill) && (col[i] == item.color);
      if (lane_hit[i]) begin
        hit   = 1'b1;
        g_hit = g_hit | IDX_W'(i);
      end
    end
  end

  assign g_sel     = hit ? g_hit : fill[IDX_W-1:0];
  assign load_go   = (state == ST_LOAD) && item_valid;
  assign item_pop  = load_go;
  assign out_free  = !out_valid || pop;
  assign tile_done = (state == ST_EM_OUT) && out_free && (kc == LAST_CNT);
  assign j_last    = (IDX_W'(j + 1'b1) == hi);
  assign top_dec   = top - 1'b1;
  assign empty     = !out_valid;

  always_comb begin
    s_we = 1'b0;
    s_wa = j;
    s_wd = s_da;
    s_ra = j;
    s_rb = ip;
    m_we = load_go;
    m_wd = item.opaque ? {1'b1, g_sel} : '0;
    p_we = 1'b0;
    p_wa = s_da.orig;
    p_wd = IDX_W'(kc - 1'b1);
    k_we = 1'b0;
    k_wd = '{lo: lo, hi: hi};
    case (state)
      ST_COPY: begin
        s_we = 1'b1;
        s_wa = kc[IDX_W-1:0];
        s_wd = '{count: cnt[0], color: col[0], orig: kc[IDX_W-1:0]};
      end
      ST_INIT: begin
        k_we = (fill != '0);
        k_wd = '{lo: '0, hi: IDX_W'(fill - 1'b1)};
      end
      ST_PIV: begin
        s_ra = hi;
      end
      ST_SCAN_CHK: begin
        s_we = (s_da.count > pivot);
        s_wa = ip;
        s_wd = s_da;
      end
      ST_SWAP2: begin
        s_we = 1'b1;
        s_wa = j;
        s_wd = tmp;
      end
      ST_FIN_RD: begin
        s_ra = hi;
      end
      ST_FIN_W1: begin
        s_we = 1'b1;
        s_wa = ip;
        s_wd = s_da;
      end
      ST_FIN_W2: begin
        s_we = 1'b1;
        s_wa = hi;
        s_wd = tmp;
      end
      ST_PUSH1: begin
        k_we = ({1'b0, ip} > ({1'b0, lo} + 1'b1));
        k_wd = '{lo: lo, hi: IDX_W'(ip - 1'b1)};
      end
      ST_PUSH2: begin
        k_we = (({1'b0, ip} + 1'b1) < {1'b0, hi});
        k_wd = '{lo: IDX_W'(ip + 1'b1), hi: hi};
      end
      ST_INV: begin
        s_ra = kc[IDX_W-1:0];
        p_we = (kc != '0);
      end
      ST_EM_RD: begin
        s_ra = kc[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  tpes_ram #(.WIDTH($bits(entry_t)), .DEPTH(TILE_PIXELS)) u_sort_ram (
    .clk(clk), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
    .rd_addr_a(s_ra), .rd_data_a(s_da), .rd_addr_b(s_rb), .rd_data_b(s_db)
  );

  tpes_ram #(.WIDTH(IDX_W + 1), .DEPTH(TILE_PIXELS)) u_map_ram (
    .clk(clk), .wr_en(m_we), .wr_addr(pos), .wr_data(m_wd),
    .rd_addr_a(kc[IDX_W-1:0]), .rd_data_a(m_rd), .rd_addr_b(kc[IDX_W-1:0]), .rd_data_b()
  );

  tpes_ram #(.WIDTH(IDX_W), .DEPTH(TILE_PIXELS)) u_posof_ram (
    .clk(clk), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
    .rd_addr_a(m_rd[IDX_W-1:0]), .rd_data_a(p_rd), .rd_addr_b(m_rd[IDX_W-1:0]),
    .rd_data_b()
  );

  tpes_ram #(.WIDTH($bits(range_t)), .DEPTH(TILE_PIXELS)) u_stack_ram (
    .clk(clk), .wr_en(k_we), .wr_addr(top[IDX_W-1:0]), .wr_data(k_wd),
    .rd_addr_a(top_dec[IDX_W-1:0]), .rd_data_a(k_rd), .rd_addr_b(top_dec[IDX_W-1:0]),
    .rd_data_b()
  );

  // palette colour cells: open on a miss, rotate out through cell 0 for the copy
  always_ff @(posedge clk) begin
    if (load_go && item.opaque && !hit) begin
      col[g_sel] <= item.color;
    end else if (state == ST_COPY) begin
      for (int i = 0; i < TILE_PIXELS; i++) begin
        col[i] <= col[(i + 1) % TILE_PIXELS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || tile_done) begin
      for (int i = 0; i < TILE_PIXELS; i++) begin
        cnt[i] <= '0;
      end
    end else if (load_go && item.opaque) begin
      for (int i = 0; i < TILE_PIXELS; i++) begin
        if (lane_hit[i]) begin
          cnt[i] <= cnt[i] + 1'b1;
        end else if (!hit && (CNT_W'(i) == fill)) begin
          cnt[i] <= CNT_W'(1);
        end
      end
    end else if (state == ST_COPY) begin
      for (int i = 0; i < TILE_PIXELS; i++) begin
        cnt[i] <= cnt[(i + 1) % TILE_PIXELS];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_POPW: begin
        lo <= k_rd.lo;
        hi <= k_rd.hi;
        ip <= k_rd.lo;
        j  <= k_rd.lo;
      end
      ST_PIVW: begin
        pivot <= s_da.count;
      end
      ST_SCAN_CHK: begin
        tmp <= s_db;
        if (s_da.count <= pivot) begin
          j <= j + 1'b1;
        end
      end
      ST_SWAP2: begin
        ip <= ip + 1'b1;
        j  <= j + 1'b1;
      end
      ST_FIN_W1: begin
        tmp <= s_db;
      end
      ST_EM_MAP: begin
        em_op  <= m_rd[IDX_W];
        em_ent <= s_da;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      fill  <= '0;
      opq   <= '0;
      pos   <= '0;
      kc    <= '0;
      top   <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (item_valid) begin
            pos <= pos + 1'b1;
            if (item.opaque) begin
              opq <= opq + 1'b1;
              if (!hit) begin
                fill <= fill + 1'b1;
              end
            end
            if (pos == LAST_IDX) begin
              pos   <= '0;
              kc    <= '0;
              state <= ST_COPY;
            end
          end
        end
        ST_COPY: begin
          kc <= kc + 1'b1;
          if (kc == LAST_CNT) begin
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          kc <= '0;
          if (fill == '0) begin
            state <= ST_INV;
          end else begin
            top   <= CNT_W'(1);
            state <= ST_POP;
          end
        end
        ST_POP: begin
          if (top == '0) begin
            kc    <= '0;
            state <= ST_INV;
          end else begin
            state <= ST_POPW;
          end
        end
        ST_POPW: begin
          top   <= top_dec;
          state <= ST_PIV;
        end
        ST_PIV: begin
          state <= ST_PIVW;
        end
        ST_PIVW: begin
          state <= (j == hi) ? ST_FIN_RD : ST_SCAN_RD;
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (s_da.count > pivot) begin
            state <= ST_SWAP2;
          end else begin
            state <= j_last ? ST_FIN_RD : ST_SCAN_RD;
          end
        end
        ST_SWAP2: begin
          state <= j_last ? ST_FIN_RD : ST_SCAN_RD;
        end
        ST_FIN_RD: begin
          state <= ST_FIN_W1;
        end
        ST_FIN_W1: begin
          state <= ST_FIN_W2;
        end
        ST_FIN_W2: begin
          state <= ST_PUSH1;
        end
        ST_PUSH1: begin
          if (k_we) begin
            top <= top + 1'b1;
          end
          state <= ST_PUSH2;
        end
        ST_PUSH2: begin
          if (k_we) begin
            top <= top + 1'b1;
          end
          state <= ST_POP;
        end
        ST_INV: begin
          if (kc == FULL_CNT) begin
            kc    <= '0;
            state <= ST_EM_RD;
          end else begin
            kc <= kc + 1'b1;
          end
        end
        ST_EM_RD: begin
          state <= ST_EM_MAP;
        end
        ST_EM_MAP: begin
          state <= ST_EM_OUT;
        end
        ST_EM_OUT: begin
          if (out_free) begin
            if (kc == LAST_CNT) begin
              kc    <= '0;
              fill  <= '0;
              opq   <= '0;
              state <= ST_LOAD;
            end else begin
              kc    <= kc + 1'b1;
              state <= ST_EM_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // result register: hold until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EM_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EM_OUT) && out_free) begin
      pixel_opaque        <= em_op;
      pixel_palette_index <= em_op ? p_rd : '0;
      entry_color         <= (kc < fill) ? em_ent.color : key;
      entry_count         <= (kc < fill) ? em_ent.count : '0;
      color_total         <= fill;
      opaque_total        <= opq;
      last_of_tile        <= (kc == LAST_CNT);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT) else $error("palette fill beyond tile size");

  a_no_intake_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> !item_pop) else $error("intake while sorting");

  a_stack_empty_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (top == '0)) else $error("sort stack not drained");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> ($stable(entry_color) && $stable(pixel_palette_index)))
    else $error("waiting result overwritten");

endmodule
`default_nettype wire

>>> sim/tb_tile_palette_extract_sort_unit.sv
`timescale 1ns / 1ps
module tb_tile_palette_extract_sort_unit;
  import tpes_pkg::*;

  typedef struct packed {
    logic               opaque;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   colors;
    logic [CNT_W-1:0]   opaques;
    logic               last;
  } beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic [COLOR_W-1:0] pixel_color = '0;
  logic               pop = 1'b0;
  logic               cfg_we = 1'b0;
  logic [COLOR_W-1:0] cfg_data = '0;
  wire                full, empty, pixel_opaque, last_of_tile;
  wire  [IDX_W-1:0]   pixel_palette_index;
  wire  [COLOR_W-1:0] entry_color;
  wire  [CNT_W-1:0]   entry_count, color_total, opaque_total;

  tile_palette_extract_sort_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel_color(pixel_color),
    .empty(empty), .pop(pop), .pixel_opaque(pixel_opaque),
    .pixel_palette_index(pixel_palette_index), .entry_color(entry_color),
    .entry_count(entry_count), .color_total(color_total),
    .opaque_total(opaque_total), .last_of_tile(last_of_tile),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // tile model state
  logic [COLOR_W-1:0] key_now;
  logic               tile_opq [TILE_PIXELS];
  int                 tile_map [TILE_PIXELS];
  logic [COLOR_W-1:0] pal_col [TILE_PIXELS];
  int                 pal_cnt [TILE_PIXELS];
  int                 n_colors, n_opaque, tile_pos;
  beat_t              expected_beats[$];
  int                 errors = 0;
  bit                 hold_pop = 1'b0;

  task automatic clear_tile_model();
    for (int p = 0; p < TILE_PIXELS; p++) begin
      tile_opq[p] = 1'b0;
      tile_map[p] = 0;
      pal_col[p] = '0;
      pal_cnt[p] = 0;
    end
    n_colors = 0;
    n_opaque = 0;
    tile_pos = 0;
  endtask

  task automatic swap_palette(input int a, input int b);
    logic [COLOR_W-1:0] tc;
    int                 tn;
    tc = pal_col[a]; pal_col[a] = pal_col[b]; pal_col[b] = tc;
    tn = pal_cnt[a]; pal_cnt[a] = pal_cnt[b]; pal_cnt[b] = tn;
    for (int p = 0; p < TILE_PIXELS; p++) begin
      if (tile_opq[p]) begin
        if (tile_map[p] == a) tile_map[p] = b;
        else if (tile_map[p] == b) tile_map[p] = a;
      end
    end
  endtask

  // iterative Lomuto quicksort, descending, right range first
  task automatic sort_palette_by_count();
    int lo_s[$];
    int hi_s[$];
    int lo, hi, i, piv;
    if (n_colors == 0) return;
    lo_s.push_back(0);
    hi_s.push_back(n_colors - 1);
    while (lo_s.size() > 0) begin
      lo = lo_s.pop_back();
      hi = hi_s.pop_back();
      piv = pal_cnt[hi];
      i = lo - 1;
      for (int j = lo; j < hi; j++) begin
        if (pal_cnt[j] > piv) begin
          i++;
          swap_palette(i, j);
        end
      end
      i++;
      swap_palette(i, hi);
      if (i - 1 > lo) begin lo_s.push_back(lo); hi_s.push_back(i - 1); end
      if (i + 1 < hi) begin lo_s.push_back(i + 1); hi_s.push_back(hi); end
    end
  endtask

  task automatic palette_add_pixel(input logic [COLOR_W-1:0] c);
    int    g;
    beat_t b;
    if (c != key_now) begin
      tile_opq[tile_pos] = 1'b1;
      n_opaque++;
      for (g = 0; g < n_colors; g++)
        if (pal_col[g] == c) break;
      if (g < n_colors) pal_cnt[g]++;
      else begin
        pal_col[g] = c;
        pal_cnt[g] = 1;
        n_colors++;
      end
      tile_map[tile_pos] = g;
    end else begin
      tile_opq[tile_pos] = 1'b0;
      tile_map[tile_pos] = 0;
    end
    tile_pos++;
    if (tile_pos == TILE_PIXELS) begin
      sort_palette_by_count();
      for (int k = 0; k < TILE_PIXELS; k++) begin
        b.opaque  = tile_opq[k];
        b.index   = tile_opq[k] ? tile_map[k][IDX_W-1:0] : '0;
        b.color   = (k < n_colors) ? pal_col[k] : key_now;
        b.count   = (k < n_colors) ? pal_cnt[k][CNT_W-1:0] : '0;
        b.colors  = n_colors[CNT_W-1:0];
        b.opaques = n_opaque[CNT_W-1:0];
        b.last    = (k == TILE_PIXELS - 1);
        expected_beats.push_back(b);
      end
      clear_tile_model();
    end
  endtask

  task automatic send_pixel(input logic [COLOR_W-1:0] c);
    int gap;
    gap = $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      push = 1'b0;
    end
    @(negedge clk);
    push = 1'b1;
    pixel_color = c;
    do @(posedge clk); while (full);
    palette_add_pixel(c);
  endtask

  task automatic end_burst();
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_key(input logic [COLOR_W-1:0] k);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = k;
    @(negedge clk);
    cfg_we = 1'b0;
    key_now = k;
  endtask

  // receiver: random gaps, held off entirely while hold_pop is set
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = $urandom_range(0, 6);
      if (w > 0) begin
        pop = 1'b0;
        repeat (w) @(negedge clk);
      end
      while (hold_pop) begin
        pop = 1'b0;
        @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    beat_t e;
    if (!rst && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat");
      end else begin
        e = expected_beats.pop_front();
        if (e.opaque !== pixel_opaque || e.index !== pixel_palette_index ||
            e.color !== entry_color || e.count !== entry_count ||
            e.colors !== color_total || e.opaques !== opaque_total ||
            e.last !== last_of_tile) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp op=%0d ix=%0d col=%h cnt=%0d tot=%0d opq=%0d last=%0d",
                     e.opaque, e.index, e.color, e.count, e.colors, e.opaques, e.last,
                     " got op=%0d ix=%0d col=%h cnt=%0d tot=%0d opq=%0d last=%0d",
                     pixel_opaque, pixel_palette_index, entry_color, entry_count,
                     color_total, opaque_total, last_of_tile);
        end
      end
    end
  end

  task automatic test_all_transparent();
    set_key('0);
    for (int p = 0; p < TILE_PIXELS; p++) send_pixel('0);
    end_burst();
    wait_drained();
  endtask

  task automatic test_all_distinct_max_key();
    set_key(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFE);
    send_pixel(24'hFFFFFF);
    for (int p = 3; p < TILE_PIXELS; p++) send_pixel({p[5:0], 18'h0} | 24'h000155);
    end_burst();
    wait_drained();
  endtask

  task automatic test_single_colour();
    set_key(24'h123456);
    for (int p = 0; p < TILE_PIXELS; p++) send_pixel(24'hA5C3F0);
    end_burst();
    wait_drained();
  endtask

  // tied counts, key changed halfway through the tile
  task automatic test_ties_key_change();
    set_key(24'h000003);
    for (int p = 0; p < 32; p++) send_pixel(COLOR_W'(p % 8));
    end_burst();
    repeat (50) @(posedge clk);
    set_key(24'h000005);
    for (int p = 32; p < TILE_PIXELS; p++) send_pixel(COLOR_W'(p % 8));
    end_burst();
    wait_drained();
  endtask

  task automatic send_random_tile();
    logic [COLOR_W-1:0] pool [TILE_PIXELS];
    int                 ncol, r;
    ncol = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
    for (int i = 0; i < ncol; i++) pool[i] = COLOR_W'($urandom());
    for (int p = 0; p < TILE_PIXELS; p++) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_pixel(key_now);
      else if (r == 1) send_pixel(COLOR_W'($urandom()));
      else send_pixel(pool[$urandom_range(0, ncol - 1)]);
    end
    end_burst();
  endtask

  task automatic test_random_tiles();
    int r;
    for (int t = 0; t < 2; t++) begin
      r = $urandom_range(0, 3);
      if (r == 0) set_key('0);
      else if (r == 1) set_key(24'hFFFFFF);
      else set_key(COLOR_W'($urandom()));
      send_random_tile();
      wait_drained();
    end
  endtask

  // receiver stalls long enough for the block to fill and refuse pixels
  task automatic test_backpressure();
    hold_pop = 1'b1;
    fork
      begin
        send_random_tile();
        send_random_tile();
      end
      begin
        repeat (12000) @(posedge clk);
        hold_pop = 1'b0;
      end
    join
    wait_drained();
  endtask

  initial begin
    key_now = '0;
    clear_tile_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_all_transparent();
    test_all_distinct_max_key();
    test_single_colour();
    test_ties_key_change();
    test_random_tiles();
    test_backpressure();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
